// ===== hw/rtl/espi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the encoder speed PI controller.
package espi_pkg;

    localparam int MUL_WIDTH = 18;
    localparam int SPEED_WIDTH = 15;
    localparam int DUTY_WIDTH = 16;
    localparam int ERR_WIDTH = 16;
    localparam int INC_WIDTH = 27;
    localparam int ACC_SUM_WIDTH = 28;
    localparam int ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [2:0] REG_WINDOW_TICKS = 3'd0;
    localparam logic [2:0] REG_SPEED_SCALE = 3'd1;
    localparam logic [2:0] REG_KP = 3'd2;
    localparam logic [2:0] REG_KI_HALF_DT = 3'd3;
    localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd4;
    localparam logic [2:0] REG_PWM_RATIO = 3'd5;

    localparam logic [7:0] WINDOW_TICKS_RESET = 8'd5;
    localparam logic [17:0] SPEED_SCALE_RESET = 18'd109227;
    localparam logic [15:0] KP_RESET = 16'd3980;
    localparam logic [15:0] KI_HALF_DT_RESET = 16'd394;
    localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'd12000;
    localparam logic [15:0] PWM_RATIO_RESET = 16'd5587;

    localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = 15'd32767;

    typedef struct packed {
        logic [7:0]  window_ticks;
        logic [17:0] speed_scale_q16;
        logic [15:0] kp_q8;
        logic [15:0] ki_half_dt_q8;
        logic [15:0] output_limit;
        logic [15:0] pwm_ratio_q16;
    } cfg_t;

endpackage

// ===== hw/rtl/espi_serial_mac.sv =====
`timescale 1ns / 1ps
// Bit-serial multiply-accumulate unit computing mul_a*cand_a + mul_b*cand_b.
module espi_serial_mac #(
    parameter int CAND_WIDTH = 17
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   start,
    input  logic [espi_pkg::MUL_WIDTH-1:0]                         mul_a,
    input  logic [espi_pkg::MUL_WIDTH-1:0]                         mul_b,
    input  logic signed [CAND_WIDTH-1:0]                           cand_a,
    input  logic signed [CAND_WIDTH-1:0]                           cand_b,
    output logic                                                   done,
    output logic signed [CAND_WIDTH+espi_pkg::MUL_WIDTH+1:0]       product
);

    localparam int MW = espi_pkg::MUL_WIDTH;
    localparam int HW = CAND_WIDTH + 2;
    localparam int CNT_WIDTH = $clog2(MW);

    logic [MW-1:0]               mul_a_reg;
    logic [MW-1:0]               mul_b_reg;
    logic signed [CAND_WIDTH-1:0] cand_a_reg;
    logic signed [CAND_WIDTH-1:0] cand_b_reg;
    logic signed [HW-1:0]        hi_reg;
    logic [MW-1:0]               lo_reg;
    logic [CNT_WIDTH-1:0]        cnt_reg;
    logic                        running_reg;
    logic                        done_reg;
    logic signed [HW-1:0]        addend;
    logic signed [HW-1:0]        sum;

    always_comb begin
        addend = (mul_a_reg[0] ? HW'(cand_a_reg) : '0) + (mul_b_reg[0] ? HW'(cand_b_reg) : '0);
        sum = hi_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                mul_a_reg <= mul_a;
                mul_b_reg <= mul_b;
                cand_a_reg <= cand_a;
                cand_b_reg <= cand_b;
                hi_reg <= '0;
                lo_reg <= '0;
                cnt_reg <= '0;
                running_reg <= 1'b1;
            end else if (running_reg) begin
                mul_a_reg <= mul_a_reg >> 1;
                mul_b_reg <= mul_b_reg >> 1;
                hi_reg <= sum >>> 1;
                lo_reg <= {sum[0], lo_reg[MW-1:1]};
                cnt_reg <= cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(MW - 1)) begin
                    running_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== hw/rtl/espi_apb_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module espi_apb_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [espi_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [espi_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [espi_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    output espi_pkg::cfg_t                       cfg
);

    espi_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_ticks <= espi_pkg::WINDOW_TICKS_RESET;
            cfg_reg.speed_scale_q16 <= espi_pkg::SPEED_SCALE_RESET;
            cfg_reg.kp_q8 <= espi_pkg::KP_RESET;
            cfg_reg.ki_half_dt_q8 <= espi_pkg::KI_HALF_DT_RESET;
            cfg_reg.output_limit <= espi_pkg::OUTPUT_LIMIT_RESET;
            cfg_reg.pwm_ratio_q16 <= espi_pkg::PWM_RATIO_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                espi_pkg::REG_WINDOW_TICKS: cfg_reg.window_ticks <= pwdata[7:0];
                espi_pkg::REG_SPEED_SCALE:  cfg_reg.speed_scale_q16 <= pwdata[17:0];
                espi_pkg::REG_KP:           cfg_reg.kp_q8 <= pwdata[15:0];
                espi_pkg::REG_KI_HALF_DT:   cfg_reg.ki_half_dt_q8 <= pwdata[15:0];
                espi_pkg::REG_OUTPUT_LIMIT: cfg_reg.output_limit <= pwdata[15:0];
                espi_pkg::REG_PWM_RATIO:    cfg_reg.pwm_ratio_q16 <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            espi_pkg::REG_WINDOW_TICKS: prdata = 32'(cfg_reg.window_ticks);
            espi_pkg::REG_SPEED_SCALE:  prdata = 32'(cfg_reg.speed_scale_q16);
            espi_pkg::REG_KP:           prdata = 32'(cfg_reg.kp_q8);
            espi_pkg::REG_KI_HALF_DT:   prdata = 32'(cfg_reg.ki_half_dt_q8);
            espi_pkg::REG_OUTPUT_LIMIT: prdata = 32'(cfg_reg.output_limit);
            espi_pkg::REG_PWM_RATIO:    prdata = 32'(cfg_reg.pwm_ratio_q16);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/espi_core.sv =====
`timescale 1ns / 1ps
// Event counters, window sequencer and PI arithmetic around the serial MAC.
module espi_core #(
    parameter int PULSE_COUNT_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  espi_pkg::cfg_t                        cfg,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic                                  s_kind,
    input  logic [espi_pkg::SPEED_WIDTH-1:0]      s_target,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [espi_pkg::SPEED_WIDTH-1:0]      m_speed,
    output logic [espi_pkg::DUTY_WIDTH-1:0]       m_duty
);

    localparam int PW = PULSE_COUNT_WIDTH;
    localparam int CW = (PW + 1 > 17) ? PW + 1 : 17;
    localparam int PRW = CW + espi_pkg::MUL_WIDTH + 2;
    localparam int MW = espi_pkg::MUL_WIDTH;
    localparam int SW = espi_pkg::SPEED_WIDTH;
    localparam int EW = espi_pkg::ERR_WIDTH;
    localparam int IW = espi_pkg::INC_WIDTH;
    localparam int AW = espi_pkg::ACC_SUM_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MSPEED,
        ST_ERR,
        ST_MPI,
        ST_ACC,
        ST_MDUTY,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [PW-1:0]          pulses_reg;
    logic [7:0]             ticks_reg;
    logic signed [EW-1:0]   prev_err_reg;
    logic [15:0]            drive_reg;
    logic [SW-1:0]          target_reg;
    logic [SW-1:0]          speed_reg;
    logic signed [EW-1:0]   err_reg;
    logic signed [IW-1:0]   inc_reg;
    logic [15:0]            duty_reg;
    logic                   m_tvalid_reg;
    logic [SW-1:0]          m_speed_reg;
    logic [15:0]            m_duty_reg;

    logic [7:0]             win;
    logic [7:0]             ticks_inc;
    logic                   window_end;
    logic                   in_accept;
    logic signed [EW-1:0]   err_next;
    logic signed [EW:0]     esum_next;
    logic                   mac_start;
    logic [MW-1:0]          mac_mul_a;
    logic [MW-1:0]          mac_mul_b;
    logic signed [CW-1:0]   mac_cand_a;
    logic signed [CW-1:0]   mac_cand_b;
    logic                   mac_done;
    logic signed [PRW-1:0]  mac_product;
    logic [SW-1:0]          speed_sat;
    logic                   round_up;
    logic signed [PRW-1:0]  quot;
    logic signed [AW-1:0]   acc_sum;
    logic [15:0]            acc_clamped;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_speed = m_speed_reg;
    assign m_duty = m_duty_reg;

    always_comb begin
        win = (cfg.window_ticks == 8'd0) ? 8'd1 : cfg.window_ticks;
        ticks_inc = ticks_reg + 8'd1;
        window_end = (ticks_inc == 8'd0) || (ticks_inc >= win);

        err_next = $signed({1'b0, target_reg}) - $signed({1'b0, speed_reg});
        esum_next = (EW + 1)'(err_next) + (EW + 1)'(prev_err_reg);

        if (mac_product[PRW-1:31] != '0) begin
            speed_sat = espi_pkg::SPEED_MAX;
        end else begin
            speed_sat = mac_product[30:16];
        end

        round_up = mac_product[PRW-1] && (mac_product[7:0] != 8'd0);
        quot = (mac_product >>> 8) + $signed(PRW'(round_up));

        acc_sum = $signed({12'd0, drive_reg}) + AW'(inc_reg);
        if (acc_sum >= $signed({12'd0, cfg.output_limit})) begin
            acc_clamped = cfg.output_limit;
        end else if (acc_sum <= 0) begin
            acc_clamped = '0;
        end else begin
            acc_clamped = acc_sum[15:0];
        end
    end

    always_comb begin
        mac_start = 1'b0;
        mac_mul_a = cfg.speed_scale_q16;
        mac_mul_b = '0;
        mac_cand_a = $signed(CW'(pulses_reg));
        mac_cand_b = '0;
        case (state_reg)
            ST_IDLE: begin
                mac_start = in_accept && (s_kind == espi_pkg::KIND_TICK) && window_end;
            end
            ST_ERR: begin
                mac_start = 1'b1;
                mac_mul_a = MW'(cfg.kp_q8);
                mac_mul_b = MW'(cfg.ki_half_dt_q8);
                mac_cand_a = CW'(err_next);
                mac_cand_b = CW'(esum_next);
            end
            ST_ACC: begin
                mac_start = 1'b1;
                mac_mul_a = MW'(cfg.pwm_ratio_q16);
                mac_cand_a = $signed(CW'(acc_clamped));
            end
            default: begin
            end
        endcase
    end

    espi_serial_mac #(
        .CAND_WIDTH(CW)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .mul_a   (mac_mul_a),
        .mul_b   (mac_mul_b),
        .cand_a  (mac_cand_a),
        .cand_b  (mac_cand_b),
        .done    (mac_done),
        .product (mac_product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pulses_reg <= '0;
            ticks_reg <= '0;
            prev_err_reg <= '0;
            drive_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (s_kind == espi_pkg::KIND_PULSE) begin
                            if (pulses_reg != '1) begin
                                pulses_reg <= pulses_reg + PW'(1);
                            end
                        end else if (window_end) begin
                            ticks_reg <= '0;
                            pulses_reg <= '0;
                            target_reg <= s_target;
                            state_reg <= ST_MSPEED;
                        end else begin
                            ticks_reg <= ticks_inc;
                        end
                    end
                end
                ST_MSPEED: begin
                    if (mac_done) begin
                        speed_reg <= speed_sat;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    err_reg <= err_next;
                    state_reg <= ST_MPI;
                end
                ST_MPI: begin
                    if (mac_done) begin
                        inc_reg <= quot[IW-1:0];
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    drive_reg <= acc_clamped;
                    prev_err_reg <= err_reg;
                    state_reg <= ST_MDUTY;
                end
                ST_MDUTY: begin
                    if (mac_done) begin
                        duty_reg <= mac_product[31:16];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_speed_reg <= speed_reg;
                        m_duty_reg <= duty_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/encoder_speed_pi_controller.sv =====
`timescale 1ns / 1ps
// Top level of the encoder speed PI controller.
//
// Each input transaction is an event: tuser low is an encoder pulse, tuser high a timer
// tick. A pulse, or a tick that does not close the measurement window, is taken without
// leaving the idle state and gives no result. A tick that closes the window starts the
// window math, which runs three passes through one bit-serial multiply-accumulate unit
// (speed, PI increment, duty), each loading its operands, shifting through the 18 multiplier
// bits and capturing the product; the result transaction becomes valid once the output
// register is free, and s_tready stays low meanwhile, so the next event is taken only after
// the result is loaded into the output register. A result still waiting in the output
// register does not block pulses or ticks that leave the window open.
module encoder_speed_pi_controller #(
    parameter int PULSE_COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [14:0] target_speed, [15] zero fill
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] measured_speed, [30:15] pwm_duty, [31] zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    espi_pkg::cfg_t                        cfg;
    logic [espi_pkg::SPEED_WIDTH-1:0]      m_speed;
    logic [espi_pkg::DUTY_WIDTH-1:0]       m_duty;

    espi_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    espi_core #(
        .PULSE_COUNT_WIDTH(PULSE_COUNT_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_target (s_tdata[14:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_speed  (m_speed),
        .m_duty   (m_duty)
    );

    assign m_tdata = {1'b0, m_duty, m_speed};

endmodule

// ===== hw/rtl/espi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the encoder speed PI controller and its bind statement.
module espi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A new result only follows a cycle in which the window math held off input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without window math");

    // An encoder pulse never starts the window math.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("pulse stalled the input");

    // The unused top bit of a valid result is always zero, and pready is high with it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[31] && pready)
        else $error("bad result fill bit or config handshake");

endmodule

bind encoder_speed_pi_controller espi_checker u_espi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the encoder speed PI controller with a predictor and stream checks.
module testbench;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam int PULSE_LIMIT = 65535;
    localparam int IDLE_PERCENT = 12;
    localparam int LONG_STALL = 600;
    localparam int SETTLE_CYCLES = 70;

    typedef struct packed {
        logic        kind;
        logic [14:0] target;
    } sensor_event_t;

    typedef struct packed {
        logic [14:0] speed;
        logic [15:0] duty;
    } window_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [espi_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    espi_pkg::cfg_t ctl_cfg;
    int model_pulses;
    logic [7:0] tick_count;
    int model_prev_err;
    int drive_value;

    sensor_event_t pending_events[$];
    window_result_t expected_results[$];

    logic s_fire = 1'b0;
    bit calm = 1'b0;
    bit long_stall_req = 1'b0;
    bit long_stall_done = 1'b0;
    int stall_left = 0;
    int failures = 0;
    int events_accepted = 0;
    int results_checked = 0;
    int reg_writes = 0;

    encoder_speed_pi_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic void reset_controller();
        ctl_cfg.window_ticks = espi_pkg::WINDOW_TICKS_RESET;
        ctl_cfg.speed_scale_q16 = espi_pkg::SPEED_SCALE_RESET;
        ctl_cfg.kp_q8 = espi_pkg::KP_RESET;
        ctl_cfg.ki_half_dt_q8 = espi_pkg::KI_HALF_DT_RESET;
        ctl_cfg.output_limit = espi_pkg::OUTPUT_LIMIT_RESET;
        ctl_cfg.pwm_ratio_q16 = espi_pkg::PWM_RATIO_RESET;
        model_pulses = 0;
        tick_count = '0;
        model_prev_err = 0;
        drive_value = 0;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            espi_pkg::REG_WINDOW_TICKS: ctl_cfg.window_ticks = value[7:0];
            espi_pkg::REG_SPEED_SCALE:  ctl_cfg.speed_scale_q16 = value[17:0];
            espi_pkg::REG_KP:           ctl_cfg.kp_q8 = value[15:0];
            espi_pkg::REG_KI_HALF_DT:   ctl_cfg.ki_half_dt_q8 = value[15:0];
            espi_pkg::REG_OUTPUT_LIMIT: ctl_cfg.output_limit = value[15:0];
            espi_pkg::REG_PWM_RATIO:    ctl_cfg.pwm_ratio_q16 = value[15:0];
            default: ;
        endcase
    endfunction

    function automatic bit step_controller(input logic kind, input logic [14:0] target,
                                           output window_result_t res);
        longint win;
        longint spd;
        longint err;
        longint inc;
        longint acc;
        longint duty;
        res = '0;
        if (kind == espi_pkg::KIND_PULSE) begin
            if (model_pulses < PULSE_LIMIT) begin
                model_pulses++;
            end
            return 1'b0;
        end
        win = (ctl_cfg.window_ticks == 8'd0) ? 1 : longint'(ctl_cfg.window_ticks);
        tick_count = tick_count + 8'd1;
        if (tick_count != 8'd0 && longint'(tick_count) < win) begin
            return 1'b0;
        end
        spd = (longint'(model_pulses) * longint'(ctl_cfg.speed_scale_q16)) >>> 16;
        if (spd > longint'(espi_pkg::SPEED_MAX)) begin
            spd = longint'(espi_pkg::SPEED_MAX);
        end
        err = longint'(target) - spd;
        inc = (longint'(ctl_cfg.kp_q8) * err
               + longint'(ctl_cfg.ki_half_dt_q8) * (err + longint'(model_prev_err))) / 256;
        acc = longint'(drive_value) + inc;
        if (acc >= longint'(ctl_cfg.output_limit)) begin
            acc = longint'(ctl_cfg.output_limit);
        end else if (acc <= 0) begin
            acc = 0;
        end
        drive_value = int'(acc);
        model_prev_err = int'(err);
        duty = (acc * longint'(ctl_cfg.pwm_ratio_q16)) >>> 16;
        model_pulses = 0;
        tick_count = '0;
        res.speed = spd[14:0];
        res.duty = duty[15:0];
        return 1'b1;
    endfunction

    function automatic void add_event(input logic kind, input logic [14:0] target);
        sensor_event_t item;
        item.kind = kind;
        item.target = target;
        pending_events.push_back(item);
    endfunction

    function automatic logic [31:0] pick_value(input logic [31:0] top);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return top;
            default: return $urandom_range(top);
        endcase
    endfunction

    function automatic espi_pkg::cfg_t random_config();
        espi_pkg::cfg_t c;
        c.window_ticks = 8'($urandom_range(1, 6));
        if ($urandom_range(0, 4) == 0) begin
            c.window_ticks = '0;
        end
        c.speed_scale_q16 = 18'(pick_value(32'd262143));
        c.kp_q8 = 16'(pick_value(32'd65535));
        c.ki_half_dt_q8 = 16'(pick_value(32'd65535));
        c.output_limit = 16'(pick_value(32'd65535));
        c.pwm_ratio_q16 = 16'(pick_value(32'd65535));
        return c;
    endfunction

    // Targets mostly sit near the speed the queued pulses will give, so the loop leaves the clamps.
    function automatic logic [14:0] pick_target(input longint pulses);
        longint approx;
        approx = (pulses * longint'(ctl_cfg.speed_scale_q16)) >>> 16;
        if (approx > 32767) begin
            approx = 32767;
        end
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return 15'($urandom);
            default: begin
                approx = approx + longint'($urandom_range(0, 80)) - 40;
                if (approx < 0) begin
                    approx = 0;
                end else if (approx > 32767) begin
                    approx = 32767;
                end
                return approx[14:0];
            end
        endcase
    endfunction

    task automatic queue_windows(input int budget, input int max_pulses);
        int added;
        int win;
        int n;
        longint window_pulses;
        added = 0;
        win = (ctl_cfg.window_ticks == 8'd0) ? 1 : int'(ctl_cfg.window_ticks);
        while (added < budget) begin
            window_pulses = 0;
            for (int t = 0; t < win; t++) begin
                n = $urandom_range(0, max_pulses);
                repeat (n) add_event(espi_pkg::KIND_PULSE, 15'($urandom));
                window_pulses += n;
                added += n + 1;
                if (t == win - 1) begin
                    add_event(espi_pkg::KIND_TICK, pick_target(window_pulses));
                end else begin
                    add_event(espi_pkg::KIND_TICK, 15'($urandom));
                end
            end
        end
        repeat ($urandom_range(0, 3)) add_event(1'($urandom_range(0, 1)), 15'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        store_reg(idx, value);
        reg_writes++;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_config(input espi_pkg::cfg_t c);
        write_reg(espi_pkg::REG_WINDOW_TICKS, 32'(c.window_ticks));
        write_reg(espi_pkg::REG_SPEED_SCALE, 32'(c.speed_scale_q16));
        write_reg(espi_pkg::REG_KP, 32'(c.kp_q8));
        write_reg(espi_pkg::REG_KI_HALF_DT, 32'(c.ki_half_dt_q8));
        write_reg(espi_pkg::REG_OUTPUT_LIMIT, 32'(c.output_limit));
        write_reg(espi_pkg::REG_PWM_RATIO, 32'(c.pwm_ratio_q16));
    endtask

    task automatic drain(input int settle);
        while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (settle) @(posedge aclk);
    endtask

    always @(negedge aclk) begin : drive_events
        sensor_event_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_fire || !s_tvalid) begin
            if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                item = pending_events.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= item.kind;
                s_tdata <= {1'b0, item.target};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            m_tready <= 1'b0;
            stall_left <= LONG_STALL;
            long_stall_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin : watch_channels
        window_result_t predicted;
        window_result_t oldest;
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                events_accepted++;
                if (step_controller(s_tuser, s_tdata[14:0], predicted)) begin
                    expected_results.push_back(predicted);
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: tdata %h", m_tdata);
                    failures++;
                end else begin
                    oldest = expected_results.pop_front();
                    results_checked++;
                    if (m_tdata[14:0] !== oldest.speed) begin
                        $error("measured_speed: expected %0d, actual %0d",
                               oldest.speed, m_tdata[14:0]);
                        failures++;
                    end
                    if (m_tdata[30:15] !== oldest.duty) begin
                        $error("pwm_duty: expected %0d, actual %0d", oldest.duty, m_tdata[30:15]);
                        failures++;
                    end
                    if (m_tdata[31] !== 1'b0) begin
                        $error("zero fill: expected 0, actual %b", m_tdata[31]);
                        failures++;
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        espi_pkg::cfg_t cfg;
        int max_pulses;
        reset_controller();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a few pulses and a full window, then a window without pulses.
        add_event(espi_pkg::KIND_PULSE, '0);
        add_event(espi_pkg::KIND_PULSE, '1);
        add_event(espi_pkg::KIND_PULSE, 15'($urandom));
        repeat (4) add_event(espi_pkg::KIND_TICK, 15'($urandom));
        add_event(espi_pkg::KIND_TICK, '1);
        repeat (4) add_event(espi_pkg::KIND_TICK, '1);
        add_event(espi_pkg::KIND_TICK, '0);
        drain(SETTLE_CYCLES);

        // A write to an unmapped register must change nothing; a zero window closes on every tick.
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(espi_pkg::REG_WINDOW_TICKS, 32'd0);
        add_event(espi_pkg::KIND_TICK, 15'd12345);
        add_event(espi_pkg::KIND_PULSE, 15'd0);
        add_event(espi_pkg::KIND_TICK, '0);
        drain(SETTLE_CYCLES);

        write_reg(espi_pkg::REG_OUTPUT_LIMIT, 32'd0);
        add_event(espi_pkg::KIND_PULSE, '0);
        add_event(espi_pkg::KIND_TICK, '1);
        drain(SETTLE_CYCLES);

        // Shorten the window below the ticks already counted.
        write_reg(espi_pkg::REG_OUTPUT_LIMIT, 32'd65535);
        write_reg(espi_pkg::REG_WINDOW_TICKS, 32'd20);
        repeat (10) add_event(espi_pkg::KIND_TICK, 15'($urandom));
        drain(SETTLE_CYCLES);
        write_reg(espi_pkg::REG_WINDOW_TICKS, 32'd3);
        add_event(espi_pkg::KIND_TICK, 15'd500);
        drain(SETTLE_CYCLES);

        for (int p = 0; p < 6; p++) begin
            cfg = random_config();
            if (p == 0) begin
                cfg.window_ticks = 8'd1;
            end
            write_config(cfg);
            long_stall_req = (p == 0);
            calm = (p == 3);
            case ($urandom_range(0, 2))
                0: max_pulses = 1;
                1: max_pulses = 4;
                default: max_pulses = 12;
            endcase
            queue_windows((p == 0) ? 80 : 260, max_pulses);
            drain(SETTLE_CYCLES);
        end
        calm = 1'b0;

        cfg = '{8'd255, 18'h3FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        write_config(cfg);
        queue_windows(270, 1);
        drain(SETTLE_CYCLES);

        cfg = '{8'd2, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        write_config(cfg);
        queue_windows(100, 3);
        drain(SETTLE_CYCLES);

        $display("Ran %0d event transactions, checked %0d window results, %0d register writes.",
                 events_accepted, results_checked, reg_writes);
        $display("Covered default, random and extreme settings and a long output stall.");
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== encoder_speed_pi_controller.f =====
hw/rtl/espi_pkg.sv
hw/rtl/espi_serial_mac.sv
hw/rtl/espi_apb_regs.sv
hw/rtl/espi_core.sv
hw/rtl/encoder_speed_pi_controller.sv
hw/rtl/espi_checker.sv
tb/sv/testbench.sv
